[design/smfc_pkg.sv]
// shared types and constants for the stereo multi-tap feedback comb
// no dependencies
package smfc_pkg;

  localparam int GAIN_W        = 16;
  localparam int FRAC_W        = 16;
  localparam int TAP_DELAY_W   = 14;
  localparam int MODE_W        = 2;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 16;
  localparam int TAP_DLY_RESET = 480;
  localparam int ROUND_HALF    = 32768;

  // reciprocal constants, exact for the value ranges that reach them
  localparam int MUL_W        = 48;
  localparam int RECIP_DIV10  = 1677722;
  localparam int SH_DIV10     = 24;
  localparam int RECIP_DIV100 = 10737419;
  localparam int SH_DIV100    = 30;
  localparam int RECIP_DIV20  = 419431;
  localparam int SH_DIV20     = 23;

  localparam logic [MODE_W-1:0] MODE_OFF        = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ONE_TAP    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TWO_TAPS   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_THREE_TAPS = 2'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE  = 2'd0,
    CFG_DELAY = 2'd1,
    CFG_GAIN  = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_MUL0,
    SEQ_MUL1,
    SEQ_MUL2,
    SEQ_ACC,
    SEQ_WB
  } seq_e;

  typedef struct packed {
    logic [GAIN_W-1:0] tap0;
    logic [GAIN_W-1:0] tap1;
    logic [GAIN_W-1:0] tap2;
  } gain_set_t;

  typedef struct packed {
    logic              rd_live;
    logic [GAIN_W-1:0] gain;
    logic              acc_init;
    logic              acc_add;
    logic              wr_en;
  } lane_ctl_t;

endpackage

[design/smfc_cfg.sv]
// configuration registers with derived tap delays and tap gains
// depends on smfc_pkg
module smfc_cfg import smfc_pkg::*; #(
  parameter int DELAY_DEPTH = 9600,
  parameter int DLY_W       = 14
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   we_i,
  input  logic [CFG_IDX_W-1:0]   index_i,
  input  logic [CFG_DATA_W-1:0]  data_i,
  output logic [MODE_W-1:0]      mode_o,
  output logic [DLY_W-1:0]       d1_o,
  output logic [DLY_W-1:0]       d2_o,
  output logic [DLY_W-1:0]       d3_o,
  output gain_set_t              gains_o,
  output logic                   clear_o
);

  function automatic logic [DLY_W-1:0] clamp_delay(input logic [TAP_DELAY_W-1:0] d);
    logic [TAP_DELAY_W:0] de;
    logic [DLY_W-1:0]     r;
    de = {1'b0, d};
    if (d == '0) begin
      r = DLY_W'(1);
    end else if (de > (TAP_DELAY_W+1)'(DELAY_DEPTH)) begin
      r = DLY_W'(DELAY_DEPTH);
    end else begin
      r = DLY_W'(de);
    end
    return r;
  endfunction

  // floor(3d/4), at least 1
  function automatic logic [DLY_W-1:0] mid_tap(input logic [DLY_W-1:0] d);
    logic [DLY_W+1:0] t;
    logic [DLY_W-1:0] r;
    t = (DLY_W+2)'(d) * (DLY_W+2)'(3);
    r = t[2 +: DLY_W];
    if (r == '0) begin
      r = DLY_W'(1);
    end
    return r;
  endfunction

  // floor(11d/20), at least 1
  function automatic logic [DLY_W-1:0] near_tap(input logic [DLY_W-1:0] d);
    logic [DLY_W+3:0] e;
    logic [MUL_W-1:0] p;
    logic [DLY_W-1:0] r;
    e = (DLY_W+4)'(d) * (DLY_W+4)'(11);
    p = MUL_W'(e) * MUL_W'(RECIP_DIV20);
    r = p[SH_DIV20 +: DLY_W];
    if (r == '0) begin
      r = DLY_W'(1);
    end
    return r;
  endfunction

  // round(0.9 g)
  function automatic logic [GAIN_W-1:0] gain_90(input logic [GAIN_W-1:0] g);
    logic [GAIN_W+3:0] v;
    logic [MUL_W-1:0]  p;
    v = (GAIN_W+4)'(g) * (GAIN_W+4)'(9) + (GAIN_W+4)'(5);
    p = MUL_W'(v) * MUL_W'(RECIP_DIV10);
    return p[SH_DIV10 +: GAIN_W];
  endfunction

  // round(0.81 g)
  function automatic logic [GAIN_W-1:0] gain_81(input logic [GAIN_W-1:0] g);
    logic [GAIN_W+6:0] v;
    logic [MUL_W-1:0]  p;
    v = (GAIN_W+7)'(g) * (GAIN_W+7)'(81) + (GAIN_W+7)'(50);
    p = MUL_W'(v) * MUL_W'(RECIP_DIV100);
    return p[SH_DIV100 +: GAIN_W];
  endfunction

  localparam logic [DLY_W-1:0] RST_D1 = clamp_delay(TAP_DELAY_W'(TAP_DLY_RESET));
  localparam logic [DLY_W-1:0] RST_D2 = mid_tap(RST_D1);
  localparam logic [DLY_W-1:0] RST_D3 = near_tap(RST_D1);

  logic [MODE_W-1:0] mode_q;
  logic [DLY_W-1:0]  d1_q, d2_q, d3_q;
  gain_set_t         gains_q;
  logic [DLY_W-1:0]  d1_new;
  logic [GAIN_W-1:0] g_new;
  logic [MODE_W-1:0] m_new;

  assign m_new  = data_i[MODE_W-1:0];
  assign d1_new = clamp_delay(data_i[TAP_DELAY_W-1:0]);
  assign g_new  = data_i[GAIN_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_OFF;
      d1_q    <= RST_D1;
      d2_q    <= RST_D2;
      d3_q    <= RST_D3;
      gains_q <= '0;
    end else if (we_i) begin
      case (cfg_idx_e'(index_i))
        CFG_MODE: begin
          mode_q <= m_new;
        end
        CFG_DELAY: begin
          d1_q <= d1_new;
          d2_q <= mid_tap(d1_new);
          d3_q <= near_tap(d1_new);
        end
        CFG_GAIN: begin
          gains_q.tap0 <= g_new;
          gains_q.tap1 <= gain_90(g_new);
          gains_q.tap2 <= gain_81(g_new);
        end
        default: begin
        end
      endcase
    end
  end

  // leaving bypass clears the write index and the fill count, so old store entries read as zero
  assign clear_o = we_i && (cfg_idx_e'(index_i) == CFG_MODE) &&
                   (mode_q == MODE_OFF) && (m_new != MODE_OFF);

  assign mode_o  = mode_q;
  assign d1_o    = d1_q;
  assign d2_o    = d2_q;
  assign d3_o    = d3_q;
  assign gains_o = gains_q;

endmodule

[design/smfc_ctrl.sv]
// input buffer, tap sequencer, write index and fill count shared by both lanes
// depends on smfc_pkg
module smfc_ctrl import smfc_pkg::*; #(
  parameter int DELAY_DEPTH  = 9600,
  parameter int SAMPLE_WIDTH = 24,
  parameter int ADDR_W       = 14,
  parameter int DLY_W        = 14
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [SAMPLE_WIDTH-1:0] left_in_i,
  input  logic signed [SAMPLE_WIDTH-1:0] right_in_i,
  input  logic [MODE_W-1:0]              mode_i,
  input  logic [DLY_W-1:0]               d1_i,
  input  logic [DLY_W-1:0]               d2_i,
  input  logic [DLY_W-1:0]               d3_i,
  input  gain_set_t                      gains_i,
  input  logic                           clear_i,
  input  logic                           room_i,
  output logic signed [SAMPLE_WIDTH-1:0] left_x_o,
  output logic signed [SAMPLE_WIDTH-1:0] right_x_o,
  output lane_ctl_t                      ctl_o,
  output logic [ADDR_W-1:0]              rd_addr_o,
  output logic [ADDR_W-1:0]              wr_addr_o,
  output logic                           done_o
);

  localparam int FILL_W = $clog2(DELAY_DEPTH + 1);
  localparam int SUM_W  = DLY_W + 1;

  seq_e                           state_q, state_d;
  logic                           buf_valid_q;
  logic signed [SAMPLE_WIDTH-1:0] buf_l_q, buf_r_q;
  logic signed [SAMPLE_WIDTH-1:0] cur_l_q, cur_r_q;
  logic [ADDR_W-1:0]              wr_q;
  logic [FILL_W-1:0]              fill_q;

  logic              start;
  logic              done;
  logic              wr_en;
  logic              acc_init;
  logic              acc_add;
  logic [DLY_W-1:0]  d_sel;
  logic [GAIN_W-1:0] g_sel;
  logic [GAIN_W-1:0] g0_eff, g1_eff, g2_eff;
  logic [SUM_W-1:0]  wr_ext, d_ext, tap_pos;
  logic [ADDR_W-1:0] rd_addr;

  assign g0_eff = (mode_i != MODE_OFF) ? gains_i.tap0 : '0;
  assign g1_eff = (mode_i == MODE_TWO_TAPS || mode_i == MODE_THREE_TAPS) ? gains_i.tap1 : '0;
  assign g2_eff = (mode_i == MODE_THREE_TAPS) ? gains_i.tap2 : '0;

  always_comb begin
    state_d = state_q;
    case (state_q)
      SEQ_IDLE: begin
        if (buf_valid_q) begin
          state_d = SEQ_MUL0;
        end
      end
      SEQ_MUL0: state_d = SEQ_MUL1;
      SEQ_MUL1: state_d = SEQ_MUL2;
      SEQ_MUL2: state_d = SEQ_ACC;
      SEQ_ACC:  state_d = SEQ_WB;
      SEQ_WB: begin
        if (room_i) begin
          state_d = SEQ_IDLE;
        end
      end
      default:  state_d = SEQ_IDLE;
    endcase
  end

  // read slot k fetches tap k, and the product of tap k is formed in the cycle after
  always_comb begin
    start    = 1'b0;
    done     = 1'b0;
    acc_init = 1'b0;
    acc_add  = 1'b0;
    d_sel    = d1_i;
    g_sel    = g0_eff;
    case (state_q)
      SEQ_IDLE: begin
        start = buf_valid_q;
      end
      SEQ_MUL0: begin
        d_sel = d2_i;
        g_sel = g0_eff;
      end
      SEQ_MUL1: begin
        d_sel    = d3_i;
        g_sel    = g1_eff;
        acc_init = 1'b1;
      end
      SEQ_MUL2: begin
        g_sel   = g2_eff;
        acc_add = 1'b1;
      end
      SEQ_ACC: begin
        acc_add = 1'b1;
      end
      SEQ_WB: begin
        done = room_i;
      end
      default: begin
      end
    endcase
  end

  assign wr_en = done && (mode_i != MODE_OFF);

  // circular tap position: wr - d, wrapped into the store
  assign wr_ext  = SUM_W'(wr_q);
  assign d_ext   = SUM_W'(d_sel);
  assign tap_pos = (wr_ext >= d_ext) ? (wr_ext - d_ext)
                                     : (wr_ext + SUM_W'(DELAY_DEPTH) - d_ext);
  assign rd_addr = tap_pos[ADDR_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SEQ_IDLE;
      buf_valid_q <= 1'b0;
      wr_q        <= '0;
      fill_q      <= '0;
    end else begin
      state_q <= state_d;
      if (in_valid_i && !in_stall_o) begin
        buf_valid_q <= 1'b1;
      end else if (start) begin
        buf_valid_q <= 1'b0;
      end
      if (clear_i) begin
        wr_q   <= '0;
        fill_q <= '0;
      end else if (wr_en) begin
        wr_q <= (wr_q == ADDR_W'(DELAY_DEPTH - 1)) ? '0 : wr_q + ADDR_W'(1);
        if (fill_q != FILL_W'(DELAY_DEPTH)) begin
          fill_q <= fill_q + FILL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      buf_l_q <= left_in_i;
      buf_r_q <= right_in_i;
    end
    if (start) begin
      cur_l_q <= buf_l_q;
      cur_r_q <= buf_r_q;
    end
  end

  assign in_stall_o = buf_valid_q;
  assign left_x_o   = cur_l_q;
  assign right_x_o  = cur_r_q;
  assign rd_addr_o  = rd_addr;
  assign wr_addr_o  = wr_q;
  assign done_o     = done;

  // entries at or past the fill count were not written since the last wipe
  assign ctl_o.rd_live  = (FILL_W'(rd_addr) < fill_q);
  assign ctl_o.gain     = g_sel;
  assign ctl_o.acc_init = acc_init;
  assign ctl_o.acc_add  = acc_add;
  assign ctl_o.wr_en    = wr_en;

endmodule

[design/smfc_lane.sv]
// one channel: delay store, tap multiply-accumulate, rounding and saturation
// depends on smfc_pkg
module smfc_lane import smfc_pkg::*; #(
  parameter int DELAY_DEPTH  = 9600,
  parameter int SAMPLE_WIDTH = 24,
  parameter int ADDR_W       = 14
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic signed [SAMPLE_WIDTH-1:0] x_i,
  input  lane_ctl_t                      ctl_i,
  input  logic [ADDR_W-1:0]              rd_addr_i,
  input  logic [ADDR_W-1:0]              wr_addr_i,
  output logic signed [SAMPLE_WIDTH-1:0] y_o
);

  localparam int PROD_W = SAMPLE_WIDTH + GAIN_W + 1;
  localparam int ACC_W  = SAMPLE_WIDTH + GAIN_W + 3;
  localparam int TOP_W  = ACC_W - FRAC_W - SAMPLE_WIDTH + 1;

  logic [SAMPLE_WIDTH-1:0]        store_q [DELAY_DEPTH];
  logic [SAMPLE_WIDTH-1:0]        rdata_q;
  logic                           live_q;
  logic signed [PROD_W-1:0]       prod_q;
  logic signed [ACC_W-1:0]        acc_q;
  logic signed [SAMPLE_WIDTH-1:0] tap;
  logic signed [ACC_W-1:0]        bias;
  logic signed [ACC_W-1:0]        shifted;
  logic [TOP_W-1:0]               top_bits;
  logic signed [SAMPLE_WIDTH-1:0] y;

  assign tap  = live_q ? $signed(rdata_q) : '0;
  // input sample scaled up, plus the half-lsb for round-half-up
  assign bias = (ACC_W'(x_i) <<< FRAC_W) + ACC_W'(ROUND_HALF);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= 1'b0;
    end else begin
      live_q <= ctl_i.rd_live;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      store_q[wr_addr_i] <= y;
    end
    rdata_q <= store_q[rd_addr_i];
    prod_q  <= $signed({1'b0, ctl_i.gain}) * tap;
    if (ctl_i.acc_init) begin
      acc_q <= bias + ACC_W'(prod_q);
    end else if (ctl_i.acc_add) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
  end

  // the top FRAC_W bits of the shifted sum only repeat the sign
  assign shifted  = acc_q >>> FRAC_W;
  assign top_bits = shifted[ACC_W-FRAC_W-1:SAMPLE_WIDTH-1];

  always_comb begin
    if (top_bits == '0 || top_bits == '1) begin
      y = shifted[SAMPLE_WIDTH-1:0];
    end else if (shifted[ACC_W-1]) begin
      y = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    end else begin
      y = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    end
  end

  assign y_o = y;

endmodule

[design/smfc_merge.sv]
// output register joining the two lane results into one stereo item
// depends on smfc_pkg
module smfc_merge import smfc_pkg::*; #(
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           take_i,
  input  logic signed [SAMPLE_WIDTH-1:0] left_y_i,
  input  logic signed [SAMPLE_WIDTH-1:0] right_y_i,
  input  logic                           out_stall_i,
  output logic                           room_o,
  output logic                           out_valid_o,
  output logic signed [SAMPLE_WIDTH-1:0] left_out_o,
  output logic signed [SAMPLE_WIDTH-1:0] right_out_o
);

  logic                           valid_q;
  logic signed [SAMPLE_WIDTH-1:0] left_q, right_q;

  assign room_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take_i) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      left_q  <= left_y_i;
      right_q <= right_y_i;
    end
  end

  assign out_valid_o = valid_q;
  assign left_out_o  = left_q;
  assign right_out_o = right_q;

endmodule

[design/stereo_multitap_feedback_comb.sv]
// stereo multi-tap feedback comb: one store and one multiply-accumulate lane per channel
// an accepted item passes states IDLE, MUL0, MUL1, MUL2, ACC and WB, waiting in WB for
//   output room; items run one at a time, set by the three tap reads through the single
//   read port of each store and the write-back of the result before the next item reads
// reset clears control and configuration; stores are not swept, a fill count makes entries
//   not written since reset or since leaving bypass read as zero
module stereo_multitap_feedback_comb import smfc_pkg::*; #(
  parameter int DELAY_DEPTH  = 9600,
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [SAMPLE_WIDTH-1:0] left_in_i,
  input  logic signed [SAMPLE_WIDTH-1:0] right_in_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [SAMPLE_WIDTH-1:0] left_out_o,
  output logic signed [SAMPLE_WIDTH-1:0] right_out_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]           cfg_index_i,
  input  logic [CFG_DATA_W-1:0]          cfg_data_i
);

  localparam int ADDR_W = $clog2(DELAY_DEPTH);
  localparam int DLY_W  = $clog2(DELAY_DEPTH + 1);

  logic [MODE_W-1:0]              mode;
  logic [DLY_W-1:0]               d1, d2, d3;
  gain_set_t                      gains;
  logic                           clear;
  logic                           room;
  logic                           seq_done;
  lane_ctl_t                      lane_ctl;
  logic [ADDR_W-1:0]              rd_addr, wr_addr;
  logic signed [SAMPLE_WIDTH-1:0] left_x, right_x;
  logic signed [SAMPLE_WIDTH-1:0] left_y, right_y;

  assign cfg_ready_o = 1'b1;

  smfc_cfg #(
    .DELAY_DEPTH(DELAY_DEPTH),
    .DLY_W      (DLY_W)
  ) u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_valid_i && cfg_ready_o),
    .index_i(cfg_index_i),
    .data_i (cfg_data_i),
    .mode_o (mode),
    .d1_o   (d1),
    .d2_o   (d2),
    .d3_o   (d3),
    .gains_o(gains),
    .clear_o(clear)
  );

  smfc_ctrl #(
    .DELAY_DEPTH (DELAY_DEPTH),
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .ADDR_W      (ADDR_W),
    .DLY_W       (DLY_W)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .left_in_i (left_in_i),
    .right_in_i(right_in_i),
    .mode_i    (mode),
    .d1_i      (d1),
    .d2_i      (d2),
    .d3_i      (d3),
    .gains_i   (gains),
    .clear_i   (clear),
    .room_i    (room),
    .left_x_o  (left_x),
    .right_x_o (right_x),
    .ctl_o     (lane_ctl),
    .rd_addr_o (rd_addr),
    .wr_addr_o (wr_addr),
    .done_o    (seq_done)
  );

  smfc_lane #(
    .DELAY_DEPTH (DELAY_DEPTH),
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .ADDR_W      (ADDR_W)
  ) u_lane_left (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .x_i      (left_x),
    .ctl_i    (lane_ctl),
    .rd_addr_i(rd_addr),
    .wr_addr_i(wr_addr),
    .y_o      (left_y)
  );

  smfc_lane #(
    .DELAY_DEPTH (DELAY_DEPTH),
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .ADDR_W      (ADDR_W)
  ) u_lane_right (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .x_i      (right_x),
    .ctl_i    (lane_ctl),
    .rd_addr_i(rd_addr),
    .wr_addr_i(wr_addr),
    .y_o      (right_y)
  );

  smfc_merge #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .take_i     (seq_done),
    .left_y_i   (left_y),
    .right_y_i  (right_y),
    .out_stall_i(out_stall_i),
    .room_o     (room),
    .out_valid_o(out_valid_o),
    .left_out_o (left_out_o),
    .right_out_o(right_out_o)
  );

  // a finished item is only handed over when the output register can hold it
  a_done_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_done |-> room)
    else $error("item finished without room in output register");

  a_done_shows_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_done |=> out_valid_o)
    else $error("finished item not presented at the output");

  // an accepted item sits in the input buffer until the sequencer picks it up
  a_accept_fills_buffer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input buffer not holding the accepted item");

  // no write to the stores unless a finished item goes out
  a_write_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lane_ctl.wr_en |-> seq_done)
    else $error("store written outside an item hand-over");

endmodule
